// File: rtl/core/sphere_texture_remap_core_macros.svh
// Assertion macros for the sphere texture remap core.
// Used by the port checker; no other dependencies.
`ifndef SPHERE_TEXTURE_REMAP_CORE_MACROS_SVH
`define SPHERE_TEXTURE_REMAP_CORE_MACROS_SVH

// antecedent implies consequent in the next cycle, ignored while in reset
`define STRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("strc assertion failed");

// same, but also checked across reset
`define STRC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("strc assertion failed");

`endif

// File: rtl/core/strc_pkg.sv
// Shared types and constants for the sphere texture remap core.
// No dependencies.
package strc_pkg;

    localparam int TEX_SIDE     = 64;
    localparam int TEX_IDX_W    = 6;
    localparam int TEX_ADDR_W   = 12;
    localparam int TEX_DEPTH    = TEX_SIDE * TEX_SIDE;
    localparam int PIX_W        = 8;
    localparam int OFS_W        = 8;
    localparam int ORG_W        = 9;
    localparam int CNT_W        = 6;
    localparam int SCR_ROW_W    = 7;
    localparam int SCR_ADDR_W   = 14;
    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 24;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_MAP     = 2'd1,
        MODE_ROW_END = 2'd2,
        MODE_FRAME   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        QD_TOP_RIGHT = 2'd0,
        QD_TOP_LEFT  = 2'd1,
        QD_BOT_LEFT  = 2'd2,
        QD_BOT_RIGHT = 2'd3
    } quad_t;

    typedef struct packed {
        logic                  last;
        logic [PIX_W-1:0]      pix;
        logic [SCR_ADDR_W-1:0] addr;
    } out_beat_t;

endpackage

// File: rtl/core/sphere_texture_remap_core.sv
// Sphere texture remap core: texture store, quadrant sequencer, output queue.
// Depends on strc_pkg.
//
// Texel loads fill a 4096-byte single-port texture memory; map entries read it
// four times (one per mirrored quadrant) and produce four screen writes, the
// fourth marked with tlast. The single memory port sets the rate: a map entry
// occupies it for its four reads, a texel load for its one write, and end-of-row
// or start-of-frame beats, like map entries past the last row, do not use it.
// The next input beat is taken in the cycle the current item's last port access
// is issued. Read results are registered and pass through a 4-deep output
// queue, which stalls the sequencer's map reads only when it would fill.
// No clearing pass after reset; the texture must be loaded before it is read.
module sphere_texture_remap_core
    import strc_pkg::*;
#(
    parameter int RADIUS        = 40,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ORG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [11:0] texel_index, [19:12] texel_value, [27:20] offset_x, [35:28] offset_y
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [13:0] screen_address, [21:14] pixel_value
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    localparam int H_W        = $clog2(SCREEN_HEIGHT + 1);
    localparam int PROD_W     = SCR_ROW_W + H_W;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0]     R6 = CNT_W'(RADIUS);
    localparam logic [SCR_ROW_W-1:0] R7 = SCR_ROW_W'(RADIUS);

    // input fields
    mode_t                 in_mode;
    logic [TEX_ADDR_W-1:0] in_texel_index;
    logic [PIX_W-1:0]      in_texel_value;
    logic [OFS_W-1:0]      in_offset_x;
    logic [OFS_W-1:0]      in_offset_y;

    assign in_mode        = mode_t'(s_tuser);
    assign in_texel_index = s_tdata[11:0];
    assign in_texel_value = s_tdata[19:12];
    assign in_offset_x    = s_tdata[27:20];
    assign in_offset_y    = s_tdata[35:28];

    // configuration
    logic [ORG_W-1:0] origin_x_reg;
    logic [ORG_W-1:0] origin_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // row / column counters
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_eff, col_eff;
    logic             row_wrap;
    logic             map_live;
    logic             s_fire;

    assign s_fire   = s_tvalid && s_tready;
    assign row_wrap = (row_reg < R6) && (col_reg >= R6);
    assign row_eff  = row_wrap ? row_reg + CNT_W'(1) : row_reg;
    assign col_eff  = row_wrap ? '0 : col_reg;
    assign map_live = row_eff < R6;

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (s_fire) begin
            case (in_mode)
                MODE_MAP: begin
                    row_next = row_eff;
                    col_next = map_live ? col_eff + CNT_W'(1) : col_eff;
                end
                MODE_ROW_END: begin
                    if (row_reg < R6) begin
                        row_next = row_reg + CNT_W'(1);
                        col_next = '0;
                    end
                end
                MODE_FRAME: begin
                    row_next = '0;
                    col_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // entry context, computed at accept
    logic [ORG_W-1:0]     x_plus, x_minus, y_plus, y_minus;
    logic [SCR_ROW_W-1:0] top_row, bot_row, right_col, left_col;
    logic [PROD_W-1:0]    right_prod, left_prod;

    assign x_plus    = origin_x_reg + ORG_W'(in_offset_x);
    assign x_minus   = origin_x_reg - ORG_W'(in_offset_x);
    assign y_plus    = origin_y_reg + ORG_W'(in_offset_y);
    assign y_minus   = origin_y_reg - ORG_W'(in_offset_y);
    assign top_row   = R7 - SCR_ROW_W'(1) - SCR_ROW_W'(row_eff);
    assign bot_row   = R7 + SCR_ROW_W'(row_eff);
    assign right_col = R7 + SCR_ROW_W'(col_eff);
    assign left_col  = R7 - SCR_ROW_W'(1) - SCR_ROW_W'(col_eff);
    assign right_prod = PROD_W'(right_col) * PROD_W'(SCREEN_HEIGHT);
    assign left_prod  = PROD_W'(left_col) * PROD_W'(SCREEN_HEIGHT);

    logic [TEX_IDX_W-1:0]  xp_reg, xm_reg, yp_reg, ym_reg;
    logic [SCR_ROW_W-1:0]  top_reg, bot_reg;
    logic [SCR_ADDR_W-1:0] rprod_reg, lprod_reg;
    logic [TEX_ADDR_W-1:0] ld_addr_reg;
    logic [PIX_W-1:0]      ld_val_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            xp_reg      <= x_plus[ORG_W-1:3];
            xm_reg      <= x_minus[ORG_W-1:3];
            yp_reg      <= y_plus[ORG_W-1:3];
            ym_reg      <= y_minus[ORG_W-1:3];
            top_reg     <= top_row;
            bot_reg     <= bot_row;
            rprod_reg   <= right_prod[SCR_ADDR_W-1:0];
            lprod_reg   <= left_prod[SCR_ADDR_W-1:0];
            ld_addr_reg <= in_texel_index;
            ld_val_reg  <= in_texel_value;
        end
    end

    // quadrant sequencer
    logic              busy_reg;
    logic              op_load_reg;
    quad_t             quad_reg;
    logic              can_issue;
    logic              step_fire;
    logic              step_last;
    logic              rd_vld_reg;
    logic [FCNT_W-1:0] fifo_cnt_reg;

    assign can_issue = (FCNT_W'(fifo_cnt_reg) + FCNT_W'(rd_vld_reg)) < FCNT_W'(FIFO_DEPTH);
    assign step_fire = busy_reg && (op_load_reg || can_issue);
    assign step_last = op_load_reg || (quad_reg == QD_BOT_RIGHT);
    assign s_tready  = !busy_reg || (step_fire && step_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            op_load_reg <= 1'b0;
            quad_reg    <= QD_TOP_RIGHT;
        end else if (s_fire && (in_mode == MODE_LOAD || (in_mode == MODE_MAP && map_live))) begin
            busy_reg    <= 1'b1;
            op_load_reg <= (in_mode == MODE_LOAD);
            quad_reg    <= QD_TOP_RIGHT;
        end else if (step_fire && step_last) begin
            busy_reg <= 1'b0;
        end else if (step_fire) begin
            quad_reg <= quad_t'(quad_reg + 2'd1);
        end
    end

    logic [TEX_IDX_W-1:0]  tex_x, tex_y;
    logic [SCR_ROW_W-1:0]  scr_row;
    logic [SCR_ADDR_W-1:0] scr_prod;
    logic                  quad_last;

    always_comb begin
        case (quad_reg)
            QD_TOP_RIGHT: begin
                tex_x = xp_reg; tex_y = ym_reg; scr_row = top_reg; scr_prod = rprod_reg;
                quad_last = 1'b0;
            end
            QD_TOP_LEFT: begin
                tex_x = xm_reg; tex_y = ym_reg; scr_row = top_reg; scr_prod = lprod_reg;
                quad_last = 1'b0;
            end
            QD_BOT_LEFT: begin
                tex_x = xm_reg; tex_y = yp_reg; scr_row = bot_reg; scr_prod = lprod_reg;
                quad_last = 1'b0;
            end
            default: begin
                tex_x = xp_reg; tex_y = yp_reg; scr_row = bot_reg; scr_prod = rprod_reg;
                quad_last = 1'b1;
            end
        endcase
    end

    // texture memory, single port
    logic [PIX_W-1:0]      tex_mem [TEX_DEPTH];
    logic [TEX_ADDR_W-1:0] mem_addr;
    logic                  mem_we, mem_re;
    logic [PIX_W-1:0]      rd_data_reg;
    logic [SCR_ADDR_W-1:0] rd_saddr_reg;
    logic                  rd_last_reg;

    assign mem_addr = op_load_reg ? ld_addr_reg : {tex_y, tex_x};
    assign mem_we   = step_fire && op_load_reg;
    assign mem_re   = step_fire && !op_load_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tex_mem[mem_addr] <= ld_val_reg;
        end
        if (mem_re) begin
            rd_data_reg <= tex_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= mem_re;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_saddr_reg <= scr_prod + SCR_ADDR_W'(scr_row);
            rd_last_reg  <= quad_last;
        end
    end

    // output queue
    out_beat_t          fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic               pop;
    out_beat_t          head;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = fifo_cnt_reg != '0;
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tdata  = {2'b00, head.pix, head.addr};
    assign m_tlast  = head.last;

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            fifo_mem[wr_ptr_reg] <= '{last: rd_last_reg, pix: rd_data_reg, addr: rd_saddr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (rd_vld_reg) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + FCNT_W'(rd_vld_reg) - FCNT_W'(pop);
        end
    end

endmodule

// File: rtl/core/strc_checker.sv
// Port-level checker for the sphere texture remap core, bound to sphere_texture_remap_core.
// Depends on strc_pkg and sphere_texture_remap_core_macros.svh.
`include "sphere_texture_remap_core_macros.svh"

module strc_checker
    import strc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    `STRC_ASSERT_NEXT_ALWAYS(a_reset_drains, aclk, !aresetn, !m_tvalid)
    `STRC_ASSERT_NEXT(a_load_one_cycle, aclk, aresetn, s_tvalid && s_tready && s_tuser == MODE_LOAD, s_tready)
    `STRC_ASSERT_NEXT(a_m_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `STRC_ASSERT_NEXT(a_m_beat_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

endmodule

bind sphere_texture_remap_core strc_checker u_strc_checker (.*);

// File: sim/sphere_texture_remap_core_checker.sv
// Scoreboard for sphere_texture_remap_core: watches config writes and both streams,
// predicts screen writes and compares them beat by beat. Depends on strc_pkg.
module sphere_texture_remap_core_checker
    import strc_pkg::*;
#(
    parameter int RADIUS        = 40,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ORG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    output int                    mismatches,
    output int                    writes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PIX_W-1:0]  texture [TEX_DEPTH];
    logic [CNT_W-1:0]  row_at;
    logic [CNT_W-1:0]  col_at;
    logic [ORG_W-1:0]  org_x;
    logic [ORG_W-1:0]  org_y;
    out_beat_t         writes_due [$];

    initial begin
        mismatches     = 0;
        writes_pending = 0;
    end

    task automatic report(string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_write(int srow, int scol, logic [ORG_W-1:0] px,
                               logic [ORG_W-1:0] py, logic last);
        out_beat_t w;
        w.addr = SCR_ADDR_W'(srow + scol * SCREEN_HEIGHT);
        w.pix  = texture[{py[ORG_W-1:3], px[ORG_W-1:3]}];
        w.last = last;
        writes_due.push_back(w);
    endtask

    task automatic predict_screen_writes(mode_t mode, logic [S_TDATA_W-1:0] d);
        logic [OFS_W-1:0] dx;
        logic [OFS_W-1:0] dy;
        logic [ORG_W-1:0] xp;
        logic [ORG_W-1:0] xm;
        logic [ORG_W-1:0] yp;
        logic [ORG_W-1:0] ym;
        int               top;
        int               bot;
        int               right;
        int               left;
        dx = d[27:20];
        dy = d[35:28];
        case (mode)
            MODE_LOAD: begin
                texture[d[11:0]] = d[19:12];
            end
            MODE_FRAME: begin
                row_at = '0;
                col_at = '0;
            end
            MODE_ROW_END: begin
                if (row_at < RADIUS) begin
                    row_at++;
                    col_at = '0;
                end
            end
            MODE_MAP: begin
                // a full row wraps on its own before the entry lands
                if (row_at < RADIUS && col_at >= RADIUS) begin
                    row_at++;
                    col_at = '0;
                end
                if (row_at < RADIUS) begin
                    xp    = org_x + ORG_W'(dx);
                    xm    = org_x - ORG_W'(dx);
                    yp    = org_y + ORG_W'(dy);
                    ym    = org_y - ORG_W'(dy);
                    top   = RADIUS - 1 - int'(row_at);
                    bot   = RADIUS + int'(row_at);
                    right = RADIUS + int'(col_at);
                    left  = RADIUS - 1 - int'(col_at);
                    queue_write(top, right, xp, ym, 1'b0);
                    queue_write(top, left,  xm, ym, 1'b0);
                    queue_write(bot, left,  xm, yp, 1'b0);
                    queue_write(bot, right, xp, yp, 1'b1);
                    col_at++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_screen_write();
        out_beat_t want;
        if (writes_due.size() == 0) begin
            report($sformatf("screen write with none due: addr %0d pix %0d last %0b",
                             m_tdata[13:0], m_tdata[21:14], m_tlast));
        end else begin
            want = writes_due.pop_front();
            if (m_tdata[13:0] !== want.addr)
                report($sformatf("screen_address got %0d want %0d", m_tdata[13:0], want.addr));
            if (m_tdata[21:14] !== want.pix)
                report($sformatf("pixel_value got %0d want %0d at addr %0d",
                                 m_tdata[21:14], want.pix, want.addr));
            if (m_tlast !== want.last)
                report($sformatf("last_write got %0b want %0b at addr %0d",
                                 m_tlast, want.last, want.addr));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            row_at = '0;
            col_at = '0;
            org_x  = '0;
            org_y  = '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ORIGIN_X: org_x = cfg_wdata;
                    CFG_ORIGIN_Y: org_y = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_screen_writes(mode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                check_screen_write();
        end
        writes_pending = writes_due.size();
    end

endmodule

// File: sim/sphere_texture_remap_core_tb.sv
// Top-level testbench for sphere_texture_remap_core: clock, reset, stimulus and verdict.
// Depends on strc_pkg, the core and sphere_texture_remap_core_checker.
module sphere_texture_remap_core_tb
    import strc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIUS        = 40;
    localparam int SCREEN_HEIGHT = 128;
    localparam int RANDOM_ITEMS  = 430;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [ORG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // [11:0] texel_index, [19:12] texel_value, [27:20] offset_x, [35:28] offset_y
    logic [S_TDATA_W-1:0]  s_tdata;
    // [1:0] mode
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [13:0] screen_address, [21:14] pixel_value
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    int   mismatches;
    int   writes_pending;
    int   cycles = 0;
    logic s_taken = 1'b0;
    bit   calm = 1'b0;

    bit               texel_known [TEX_DEPTH];
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    int               row_at;
    int               col_at;
    int               items = 0;

    always #5 aclk = ~aclk;

    sphere_texture_remap_core #(
        .RADIUS(RADIUS), .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) dut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

    sphere_texture_remap_core_checker #(
        .RADIUS(RADIUS), .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) checker_i (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .mismatches, .writes_pending
    );

    always @(posedge aclk) s_taken <= s_tvalid && s_tready;

    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 13);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(mode_t mode, logic [11:0] idx, logic [7:0] val,
                             logic [7:0] dx, logic [7:0] dy, bit counts);
        if (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, dy, dx, val, idx};
        @(negedge aclk);
        while (!s_taken) @(negedge aclk);
        if (counts) items++;
        calm = (items >= 150 && items < 260);
    endtask

    function automatic logic [7:0] pick_dx();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd254;
            default: return 8'($urandom_range(254));
        endcase
    endfunction

    function automatic logic [7:0] pick_dy();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [ORG_W-1:0] pick_origin();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return ORG_W'($urandom_range(511));
        endcase
    endfunction

    task automatic load_texel(logic [11:0] idx, logic [7:0] val);
        send_beat(MODE_LOAD, idx, val, 8'($urandom), 8'($urandom), 1'b1);
        texel_known[idx] = 1'b1;
    endtask

    task automatic frame_start();
        send_beat(MODE_FRAME, 12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'b1);
        row_at = 0;
        col_at = 0;
    endtask

    task automatic row_end();
        bit live;
        live = row_at < RADIUS;
        if (live) begin
            row_at++;
            col_at = 0;
        end
        send_beat(MODE_ROW_END, 12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  live);
    endtask

    // for a live entry, loads any texel the entry would read that was never written
    task automatic map_entry(logic [7:0] dx, logic [7:0] dy);
        logic [ORG_W-1:0] xs [2];
        logic [ORG_W-1:0] ys [2];
        logic [11:0]      idx;
        bit               live;
        if (row_at < RADIUS && col_at >= RADIUS) begin
            row_at++;
            col_at = 0;
        end
        live = row_at < RADIUS;
        if (live) begin
            xs[0] = origin_x + ORG_W'(dx);
            xs[1] = origin_x - ORG_W'(dx);
            ys[0] = origin_y + ORG_W'(dy);
            ys[1] = origin_y - ORG_W'(dy);
            foreach (ys[i]) begin
                foreach (xs[j]) begin
                    idx = {ys[i][ORG_W-1:3], xs[j][ORG_W-1:3]};
                    if (!texel_known[idx]) load_texel(idx, 8'($urandom));
                end
            end
            col_at++;
        end
        send_beat(MODE_MAP, 12'($urandom), 8'($urandom), dx, dy, live);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (writes_pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_origin(logic [ORG_W-1:0] ox, logic [ORG_W-1:0] oy);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ORIGIN_X;
        cfg_wdata <= ox;
        @(negedge aclk);
        cfg_addr  <= CFG_ORIGIN_Y;
        cfg_wdata <= oy;
        @(negedge aclk);
        cfg_we   <= 1'b0;
        origin_x = ox;
        origin_y = oy;
    endtask

    // jumps down a number of rows, then overfills one row so it wraps by itself
    task automatic dive_frame(int skip_rows);
        frame_start();
        repeat (skip_rows) row_end();
        repeat (RADIUS + $urandom_range(1, 2)) map_entry(pick_dx(), pick_dy());
        row_end();
        map_entry(pick_dx(), pick_dy());
    endtask

    task automatic sweep_frame(int target);
        int n;
        int roll;
        frame_start();
        while (row_at < RADIUS && items < target) begin
            roll = $urandom_range(99);
            n = (roll < 5) ? RADIUS : (roll < 8) ? RADIUS + $urandom_range(1, 3)
                                                 : $urandom_range(0, 4);
            repeat (n) map_entry(pick_dx(), pick_dy());
            roll = $urandom_range(99);
            if (roll < 85) begin
                row_end();
            end else if (roll < 91) begin
                load_texel(12'($urandom), 8'($urandom));
            end else if (roll < 94) begin
                break;
            end
        end
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(1)) row_end();
            else map_entry(pick_dx(), pick_dy());
        end
    endtask

    initial begin
        int target;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_LOAD;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_origin('0, '0);
        frame_start();
        load_texel(12'd0, 8'h00);
        load_texel(12'hFFF, 8'hFF);
        map_entry(8'd0, 8'd0);
        map_entry(8'd254, 8'd255);
        row_end();
        map_entry(8'd8, 8'd8);
        row_end();
        row_end();
        map_entry(8'd1, 8'd1);
        frame_start();
        map_entry(8'd128, 8'd128);
        settle();
        set_origin('1, '1);
        map_entry(8'd0, 8'd0);
        map_entry(8'd254, 8'd255);
        row_end();
        map_entry(8'd7, 8'd200);
        frame_start();

        target = items + RANDOM_ITEMS;
        dive_frame(RADIUS - 1);
        while (items < target) begin
            settle();
            set_origin(pick_origin(), pick_origin());
            if ($urandom_range(4) == 0) dive_frame($urandom_range(0, RADIUS - 1));
            else sweep_frame(target);
        end

        settle();
        if (mismatches == 0 && writes_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sphere_texture_remap_core.f
+incdir+rtl/core
rtl/core/strc_pkg.sv
rtl/core/sphere_texture_remap_core.sv
rtl/core/strc_checker.sv
sim/sphere_texture_remap_core_checker.sv
sim/sphere_texture_remap_core_tb.sv
